// ===== src/sde_pkg.sv =====
`timescale 1ns / 1ps
package sde_pkg;

	localparam int          DefaultMaxRatio = 16;
	localparam logic [31:0] OneQ31          = 32'h7FFF_FFFF;
	localparam logic [31:0] MinQ31          = 32'h8000_0000;
	localparam int          AddrW           = 5;

	// register indexes
	localparam logic [2:0] RegThreshold  = 3'd0;
	localparam logic [2:0] RegRatio      = 3'd1;
	localparam logic [2:0] RegEnvAttack  = 3'd2;
	localparam logic [2:0] RegEnvRelease = 3'd3;
	localparam logic [2:0] RegGainAttack = 3'd4;
	localparam logic [2:0] RegGainRelease= 3'd5;
	localparam logic [2:0] RegMakeup     = 3'd6;

	typedef struct packed {
		logic [30:0] threshold;
		logic [4:0]  ratio;
		logic [30:0] env_attack;
		logic [30:0] env_release;
		logic [30:0] gain_attack;
		logic [30:0] gain_release;
		logic [30:0] makeup;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic res_vld;
	} lane_stat_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return OneQ31;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			return MinQ31;
		end
		return v[31:0];
	endfunction

	// floor shift of a product, then saturate
	function automatic logic signed [31:0] q31(input logic signed [63:0] p);
		return sat64(p >>> 31);
	endfunction

	function automatic logic signed [31:0] q27(input logic signed [63:0] p);
		return sat64(p >>> 27);
	endfunction

	function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'sh0_7FFF_FFFF) begin
			return OneQ31;
		end else if (s < -33'sh0_8000_0000) begin
			return MinQ31;
		end
		return s[31:0];
	endfunction

endpackage

// ===== src/stereo_downward_expander_unit.sv =====
`timescale 1ns / 1ps
// Stereo downward expander.
// Input channel: in_valid/in_stall carry one word (left_in, right_in, frame_end).
// Output channel: out_valid/out_stall carry left_out, right_out, frame_end_out.
// Configuration: APB port, register i at byte address 4*i, pready tied high;
// write registers only while the block is idle.
// Each channel has its own lane with one 32x32 multiplier and a shift-subtract
// divider; a merge register joins the two results.
// The divide and the power loop, one multiply per power of the ratio (ratio capped
// at MAX_RATIO), run only when the envelope is below threshold.
// One word is in process at a time; in_stall stays high until both lanes are free
// again, so the lane sequence with its divide and power loop, and any output stall, set the rate.
// A finished word waits in the output register while the next one is taken.
// When the receiver stalls, the output word holds and the lanes hold results
// until the output register frees.
// Reset clears envelopes to zero, smoothed gains to one and registers to
// their defaults (threshold one, ratio 1, makeup 1.0 in Q27).
module stereo_downward_expander_unit #(
	parameter int MAX_RATIO = sde_pkg::DefaultMaxRatio
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sde_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [31:0]         left_in,
	input  logic signed [31:0]         right_in,
	input  logic                       frame_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [31:0]         left_out,
	output logic signed [31:0]         right_out,
	output logic                       frame_end_out
);
	sde_pkg::cfg_t       cfg_q;
	sde_pkg::lane_stat_t l_stat, r_stat;
	logic signed [31:0]  l_y, r_y, left_q, right_q;
	logic                fe_in_q, fe_q, out_valid_q;
	logic                accept, load;
	logic [2:0]          idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= 31'h7FFF_FFFF;
			cfg_q.ratio        <= 5'd1;
			cfg_q.env_attack   <= '0;
			cfg_q.env_release  <= '0;
			cfg_q.gain_attack  <= '0;
			cfg_q.gain_release <= '0;
			cfg_q.makeup       <= 31'h0800_0000;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				sde_pkg::RegThreshold:   cfg_q.threshold    <= pwdata[30:0];
				sde_pkg::RegRatio:       cfg_q.ratio        <= pwdata[4:0];
				sde_pkg::RegEnvAttack:   cfg_q.env_attack   <= pwdata[30:0];
				sde_pkg::RegEnvRelease:  cfg_q.env_release  <= pwdata[30:0];
				sde_pkg::RegGainAttack:  cfg_q.gain_attack  <= pwdata[30:0];
				sde_pkg::RegGainRelease: cfg_q.gain_release <= pwdata[30:0];
				sde_pkg::RegMakeup:      cfg_q.makeup       <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sde_pkg::RegThreshold:   prdata = {1'b0, cfg_q.threshold};
			sde_pkg::RegRatio:       prdata = {27'b0, cfg_q.ratio};
			sde_pkg::RegEnvAttack:   prdata = {1'b0, cfg_q.env_attack};
			sde_pkg::RegEnvRelease:  prdata = {1'b0, cfg_q.env_release};
			sde_pkg::RegGainAttack:  prdata = {1'b0, cfg_q.gain_attack};
			sde_pkg::RegGainRelease: prdata = {1'b0, cfg_q.gain_release};
			sde_pkg::RegMakeup:      prdata = {1'b0, cfg_q.makeup};
			default:                 prdata = '0;
		endcase
	end

	assign in_stall = !(l_stat.idle && r_stat.idle);
	assign accept   = in_valid && !in_stall;
	// merge once both lanes finish and the output register is free
	assign load     = l_stat.res_vld && r_stat.res_vld && (!out_valid_q || !out_stall);

	sde_lane #(.MAX_RATIO(MAX_RATIO)) u_left (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(accept), .x(left_in),
		.take(load), .y(l_y), .stat(l_stat)
	);

	sde_lane #(.MAX_RATIO(MAX_RATIO)) u_right (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(accept), .x(right_in),
		.take(load), .y(r_y), .stat(r_stat)
	);

	always_ff @(posedge clk) begin
		if (accept) fe_in_q <= frame_end;
		if (load) begin
			left_q  <= l_y;
			right_q <= r_y;
			fe_q    <= fe_in_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_out      = left_q;
	assign right_out     = right_q;
	assign frame_end_out = fe_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall) else $error("lanes not busy after accept");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !load |=> !out_valid_q)
		else $error("output word repeated");

	a_merge_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(l_stat.res_vld && r_stat.res_vld))
		else $error("output without both lane results");

endmodule

// ===== src/sde_lane.sv =====
`timescale 1ns / 1ps
module sde_lane #(
	parameter int MAX_RATIO = sde_pkg::DefaultMaxRatio
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sde_pkg::cfg_t        cfg,
	input  logic                 start,
	input  logic signed [31:0]   x,
	input  logic                 take,
	output logic signed [31:0]   y,
	output sde_pkg::lane_stat_t  stat
);
	localparam int KW = $clog2(MAX_RATIO + 1);

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001, S_E1  = 19'h00002, S_E2  = 19'h00004, S_E3  = 19'h00008,
		S_CMP  = 19'h00010, S_DIV = 19'h00020, S_POW = 19'h00040, S_PWA = 19'h00080,
		S_PWB  = 19'h00100, S_SM0 = 19'h00200, S_SM1 = 19'h00400, S_SM2 = 19'h00800,
		S_SM3  = 19'h01000, S_MK0 = 19'h02000, S_MK1 = 19'h04000, S_MK2 = 19'h08000,
		S_Y1   = 19'h10000, S_Y2  = 19'h20000, S_DONE = 19'h40000
	} state_t;

	state_t             state_q;
	logic signed [31:0] env_q, gain_q, x_q, mag_q, c_q, acc_q, gc_q, quo_q, rem_q, y_q;
	logic signed [31:0] ma_q, mb_q;
	logic signed [63:0] p_q;
	logic [4:0]         cnt_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      n;
	logic signed [31:0] mag, ecoef, gcoef, thr, pq31;
	logic [31:0]        rem2;

	assign n    = (32'(cfg.ratio) > MAX_RATIO) ? KW'(MAX_RATIO) : KW'(cfg.ratio);
	assign mag  = (x == sde_pkg::MinQ31) ? sde_pkg::OneQ31 : ((x < 0) ? -x : x);
	assign ecoef = (mag > env_q) ? {1'b0, cfg.env_attack} : {1'b0, cfg.env_release};
	assign gcoef = (gc_q <= gain_q) ? {1'b0, cfg.gain_attack} : {1'b0, cfg.gain_release};
	assign thr  = {1'b0, cfg.threshold};
	assign pq31 = sde_pkg::q31(p_q);
	assign rem2 = {rem_q[30:0], 1'b0};

	always_ff @(posedge clk) begin
		p_q <= 64'(ma_q) * 64'(mb_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			env_q   <= '0;
			gain_q  <= sde_pkg::OneQ31;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					x_q <= x; mag_q <= mag; c_q <= ecoef;
					ma_q <= ecoef; mb_q <= env_q;
					state_q <= S_E1;
				end
				S_E1: begin
					ma_q <= sde_pkg::OneQ31 - c_q; mb_q <= mag_q;
					state_q <= S_E2;
				end
				S_E2: begin
					acc_q <= pq31;
					state_q <= S_E3;
				end
				S_E3: begin
					env_q <= sde_pkg::sadd(acc_q, pq31);
					state_q <= S_CMP;
				end
				S_CMP: begin
					gc_q <= sde_pkg::OneQ31;
					if (env_q < thr) begin
						rem_q <= env_q; quo_q <= '0; cnt_q <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_SM0;
					end
				end
				// restoring divide, one quotient bit per cycle
				S_DIV: begin
					if (rem2 >= 32'(thr)) begin
						rem_q <= rem2 - 32'(thr);
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) state_q <= S_POW;
				end
				S_POW: begin
					ma_q <= quo_q; mb_q <= gc_q; k_q <= '0;
					state_q <= (n == '0) ? S_SM0 : S_PWA;
				end
				S_PWA: state_q <= S_PWB;
				S_PWB: begin
					gc_q <= pq31; mb_q <= pq31;
					k_q  <= k_q + 1'b1;
					state_q <= ((KW+1)'(k_q) + 1'b1 == (KW+1)'(n)) ? S_SM0 : S_PWA;
				end
				S_SM0: begin
					c_q <= gcoef; ma_q <= gcoef; mb_q <= gain_q;
					state_q <= S_SM1;
				end
				S_SM1: begin
					ma_q <= sde_pkg::OneQ31 - c_q; mb_q <= gc_q;
					state_q <= S_SM2;
				end
				S_SM2: begin
					acc_q <= pq31;
					state_q <= S_SM3;
				end
				S_SM3: begin
					gain_q <= sde_pkg::sadd(acc_q, pq31);
					state_q <= S_MK0;
				end
				S_MK0: begin
					ma_q <= gain_q; mb_q <= {1'b0, cfg.makeup};
					state_q <= S_MK1;
				end
				S_MK1: state_q <= S_MK2;
				S_MK2: begin
					ma_q <= x_q; mb_q <= sde_pkg::q27(p_q);
					state_q <= S_Y1;
				end
				S_Y1: state_q <= S_Y2;
				S_Y2: begin
					y_q <= pq31;
					state_q <= S_DONE;
				end
				S_DONE: if (take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign y            = y_q;
	assign stat.idle    = (state_q == S_IDLE);
	assign stat.res_vld = (state_q == S_DONE);

endmodule
